// File: design/ksh_pkg.sv
package ksh_pkg;

    localparam int MAX_ROUNDS_DEF = 48;
    localparam int DEF_ROUNDS     = 24;
    localparam int LANES          = 25;
    localparam int LANE_W         = 64;
    localparam int STATE_BYTES    = 200;
    localparam int MAX_OUT_LEN    = 99;
    localparam int CFG_W          = 7;
    localparam int CFG_IDX_W      = 2;

    localparam logic [7:0] PAD_KECCAK = 8'h01;
    localparam logic [7:0] PAD_SHA3   = 8'h06;
    localparam logic [7:0] PAD_LAST   = 8'h80;
    localparam logic [7:0] LFSR_POLY  = 8'h71;
    localparam logic [7:0] LFSR_INIT  = 8'h01;

    localparam logic [5:0] RST_ROUNDS  = 6'd24;
    localparam logic [6:0] RST_OUT_LEN = 7'd32;
    localparam logic       RST_PAD     = 1'b1;

    typedef enum logic [1:0] {
        CMD_START   = 2'd0,
        CMD_ABSORB  = 2'd1,
        CMD_SQUEEZE = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_ROUND_COUNT   = 2'd0,
        CFG_OUTPUT_LENGTH = 2'd1,
        CFG_PAD_MODE      = 2'd2,
        CFG_UNUSED        = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ABSORB,
        S_PAD,
        S_PAD_END,
        S_SQZ,
        S_PERM
    } t_fsm;

    typedef logic [LANES-1:0][LANE_W-1:0] t_state;

    typedef struct packed {
        logic [LANE_W-1:0] rc;
        logic [7:0]        lfsr;
    } t_rc_step;

    localparam int RHO [LANES] = '{
        0, 1, 62, 28, 27,
        36, 44, 6, 55, 20,
        3, 10, 43, 25, 39,
        41, 45, 15, 21, 8,
        18, 2, 61, 56, 14
    };

    // Seven LFSR steps give the round constant of one round.
    function automatic t_rc_step rc_step(input logic [7:0] lfsr);
        t_rc_step   r;
        logic [7:0] s;
        s    = lfsr;
        r.rc = '0;
        for (int j = 0; j < 7; j++) begin
            r.rc[(1 << j) - 1] = s[0];
            s = {s[6:0], 1'b0} ^ (s[7] ? LFSR_POLY : 8'h00);
        end
        r.lfsr = s;
        return r;
    endfunction

endpackage

// File: design/ksh_in_if.sv
interface ksh_in_if
    import ksh_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] data_byte;

    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

// File: design/ksh_out_if.sv
interface ksh_out_if
    import ksh_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       overrun;

    modport source (output valid, output out_byte, output overrun, input ready);
    modport sink   (input valid, input out_byte, input overrun, output ready);
endinterface

// File: design/ksh_round.sv
module ksh_round
    import ksh_pkg::*;
(
    input  t_state            i_state,
    input  logic [LANE_W-1:0] i_rc,
    output t_state            o_state
);

    logic [4:0][LANE_W-1:0] c;
    logic [4:0][LANE_W-1:0] d;
    t_state                 b;

    genvar x, y;
    generate
        for (x = 0; x < 5; x++) begin : g_theta
            assign c[x] = i_state[x] ^ i_state[x+5] ^ i_state[x+10]
                        ^ i_state[x+15] ^ i_state[x+20];
        end
        for (x = 0; x < 5; x++) begin : g_d
            localparam int XM = (x + 4) % 5;
            localparam int XP = (x + 1) % 5;
            assign d[x] = c[XM] ^ {c[XP][LANE_W-2:0], c[XP][LANE_W-1]};
        end
        for (y = 0; y < 5; y++) begin : g_rp_y
            for (x = 0; x < 5; x++) begin : g_rp_x
                localparam int SRC = x + 5 * y;
                localparam int DST = y + 5 * ((2 * x + 3 * y) % 5);
                localparam int ROT = RHO[SRC];
                logic [LANE_W-1:0] a;
                assign a      = i_state[SRC] ^ d[x];
                assign b[DST] = (a << ROT) | (a >> (LANE_W - ROT));
            end
        end
        for (y = 0; y < 5; y++) begin : g_chi_y
            for (x = 0; x < 5; x++) begin : g_chi_x
                localparam int I  = x + 5 * y;
                localparam int I1 = (x + 1) % 5 + 5 * y;
                localparam int I2 = (x + 2) % 5 + 5 * y;
                if (I == 0) begin : g_iota
                    assign o_state[I] = b[I] ^ (~b[I1] & b[I2]) ^ i_rc;
                end else begin : g_plain
                    assign o_state[I] = b[I] ^ (~b[I1] & b[I2]);
                end
            end
        end
    endgenerate

endmodule

// File: design/keccak_sponge_hash_top.sv
// Byte-wide Keccak-f[1600] sponge, Keccak or SHA3 padding.
// Input channel i_in carries cmd and data_byte: start clears the state,
// absorb XORs one byte, squeeze returns one digest byte (or overrun) on o_out.
// Start and unknown commands finish in idle; an absorb passes S_ABSORB
// (after squeezing it first clears the byte index), a squeeze S_SQZ to the
// output register. A permutation runs when an absorb, pad or Keccak-mode
// squeeze finds the block full: one round per cycle from a single round
// unit, round_count rounds (0 means 24, capped at MAX_ROUNDS). The first
// squeeze pads and permutes, first permuting a full block. One item is
// worked at a time: i_in.ready is high only when the sequencer is idle.
// Config writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at once and
// belong between items only. Synchronous active-low reset clears the
// state, the byte index and the squeeze flag, and loads 24 rounds,
// 32 digest bytes and SHA3 padding. A result waits in the output register
// while o_out.ready is low; the next item is accepted meanwhile and its
// squeeze holds until the register frees up.
module keccak_sponge_hash_top
    import ksh_pkg::*;
#(
    parameter int MAX_ROUNDS = MAX_ROUNDS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    ksh_in_if.sink               i_in,
    ksh_out_if.source            o_out
);

    localparam int RND_W = $clog2(MAX_ROUNDS + 1);
    localparam int CMP_W = RND_W > 6 ? RND_W : 6;

    t_state      r_state, n_state;
    t_state      round_out;
    logic [7:0]  r_idx, n_idx;
    logic        r_sqz, n_sqz;
    t_fsm        r_fsm, n_fsm, r_ret, n_ret;
    logic [7:0]  r_data, n_data;
    logic [RND_W-1:0] r_rnd, n_rnd;
    logic [7:0]  r_lfsr, n_lfsr;
    logic [5:0]  r_round_count;
    logic [6:0]  r_out_len;
    logic        r_pad_mode;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_byte, n_out_byte;
    logic        r_overrun, n_overrun;

    logic [6:0]       out_len_sat;
    logic [7:0]       rate;
    logic [7:0]       rate_last;
    logic [CMP_W-1:0] rc_ext;
    logic [RND_W-1:0] rounds;
    logic             full_blk;
    logic             slot_free;
    t_rc_step         rcs;

    assign out_len_sat = (r_out_len > 7'(MAX_OUT_LEN)) ? 7'(MAX_OUT_LEN) : r_out_len;
    assign rate        = 8'(STATE_BYTES) - {out_len_sat, 1'b0};
    assign rate_last   = rate - 8'd1;
    assign full_blk    = (r_idx >= rate);
    assign rc_ext      = CMP_W'(r_round_count);
    assign rounds      = (r_round_count == 6'd0) ? RND_W'(DEF_ROUNDS) :
                         (rc_ext > CMP_W'(MAX_ROUNDS)) ? RND_W'(MAX_ROUNDS) :
                         RND_W'(r_round_count);
    assign rcs         = rc_step(r_lfsr);
    assign slot_free   = !r_out_valid || o_out.ready;

    ksh_round u_round (
        .i_state (r_state),
        .i_rc    (rcs.rc),
        .o_state (round_out)
    );

    assign i_in.ready     = (r_fsm == S_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.overrun  = r_overrun;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_sqz       = r_sqz;
        n_fsm       = r_fsm;
        n_ret       = r_ret;
        n_data      = r_data;
        n_rnd       = r_rnd;
        n_lfsr      = r_lfsr;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_byte  = r_out_byte;
        n_overrun   = r_overrun;
        case (r_fsm)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_data = i_in.data_byte;
                    case (i_in.cmd)
                        CMD_START: begin
                            n_state = '0;
                            n_idx   = '0;
                            n_sqz   = 1'b0;
                        end
                        CMD_ABSORB:  n_fsm = S_ABSORB;
                        CMD_SQUEEZE: n_fsm = r_sqz ? S_SQZ : S_PAD;
                        default: ;
                    endcase
                end
            end
            S_ABSORB: begin
                if (r_sqz) begin
                    n_sqz = 1'b0;
                    n_idx = '0;
                end else if (full_blk) begin
                    n_idx  = '0;
                    n_ret  = S_ABSORB;
                    n_fsm  = S_PERM;
                    n_rnd  = '0;
                    n_lfsr = LFSR_INIT;
                end else begin
                    n_state[r_idx[7:3]][{r_idx[2:0], 3'b000} +: 8] =
                        r_state[r_idx[7:3]][{r_idx[2:0], 3'b000} +: 8] ^ r_data;
                    n_idx = r_idx + 8'd1;
                    n_fsm = S_IDLE;
                end
            end
            S_PAD: begin
                if (full_blk) begin
                    n_idx  = '0;
                    n_ret  = S_PAD;
                    n_fsm  = S_PERM;
                    n_rnd  = '0;
                    n_lfsr = LFSR_INIT;
                end else begin
                    n_state[r_idx[7:3]][{r_idx[2:0], 3'b000} +: 8] =
                        r_state[r_idx[7:3]][{r_idx[2:0], 3'b000} +: 8]
                        ^ (r_pad_mode ? PAD_SHA3 : PAD_KECCAK);
                    n_fsm = S_PAD_END;
                end
            end
            S_PAD_END: begin
                n_state[rate_last[7:3]][{rate_last[2:0], 3'b000} +: 8] =
                    r_state[rate_last[7:3]][{rate_last[2:0], 3'b000} +: 8] ^ PAD_LAST;
                n_idx  = '0;
                n_sqz  = 1'b1;
                n_ret  = S_SQZ;
                n_fsm  = S_PERM;
                n_rnd  = '0;
                n_lfsr = LFSR_INIT;
            end
            S_SQZ: begin
                if (r_pad_mode && (r_idx >= 8'(STATE_BYTES))) begin
                    if (slot_free) begin
                        n_idx       = 8'(STATE_BYTES);
                        n_out_valid = 1'b1;
                        n_out_byte  = '0;
                        n_overrun   = 1'b1;
                        n_fsm       = S_IDLE;
                    end
                end else if (!r_pad_mode && full_blk) begin
                    n_idx  = '0;
                    n_ret  = S_SQZ;
                    n_fsm  = S_PERM;
                    n_rnd  = '0;
                    n_lfsr = LFSR_INIT;
                end else if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_state[r_idx[7:3]][{r_idx[2:0], 3'b000} +: 8];
                    n_overrun   = 1'b0;
                    n_idx       = r_idx + 8'd1;
                    n_fsm       = S_IDLE;
                end
            end
            S_PERM: begin
                n_state = round_out;
                n_lfsr  = rcs.lfsr;
                n_rnd   = r_rnd + RND_W'(1);
                if (r_rnd == rounds - RND_W'(1)) begin
                    n_fsm = r_ret;
                end
            end
            default: n_fsm = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_idx       <= '0;
            r_sqz       <= 1'b0;
            r_fsm       <= S_IDLE;
            r_ret       <= S_IDLE;
            r_rnd       <= '0;
            r_lfsr      <= LFSR_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_sqz       <= n_sqz;
            r_fsm       <= n_fsm;
            r_ret       <= n_ret;
            r_rnd       <= n_rnd;
            r_lfsr      <= n_lfsr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data     <= n_data;
        r_out_byte <= n_out_byte;
        r_overrun  <= n_overrun;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round_count <= RST_ROUNDS;
            r_out_len     <= RST_OUT_LEN;
            r_pad_mode    <= RST_PAD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROUND_COUNT:   r_round_count <= i_cfg_data[5:0];
                CFG_OUTPUT_LENGTH: r_out_len     <= i_cfg_data;
                CFG_PAD_MODE:      r_pad_mode    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule
